// File: rtl/core/zgfr_pkg.sv
// Package for the zone-grid to frame remapper.
// Shared types, codes and frame geometry constants; no dependencies.
package zgfr_pkg;

  localparam int unsigned FRAME_CELLS = 64;
  localparam int unsigned CELL_W      = 6;
  localparam int unsigned DIST_W      = 16;
  localparam int unsigned ISS_W       = 7;

  // Request kinds on the input channel
  typedef enum logic [1:0] {
    KIND_ZONE  = 2'd0,
    KIND_BLANK = 2'd1,
    KIND_READ  = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BLOCK,
    ST_READ,
    ST_STALE
  } state_t;

  // Result of mapping one zone onto the frame
  typedef struct packed {
    logic              hit;    // zone lands inside the frame
    logic              block;  // 4x4 mode: fills a 2x2 block
    logic [CELL_W-1:0] base;   // first (top-left) cell written
  } zone_map_t;

endpackage

// File: rtl/core/zone_grid_to_frame_remap.sv
// Top level of the zone-grid to 8x8 frame remapper.
// Uses zgfr_pkg, zgfr_zone_map and zgfr_frame_mem.
//
//   channel  handshake            payload
//   in_      in_valid/in_ready    kind, zone_num, zone_count, target_count,
//                                 zone_status, range_mm, last_zone
//   out_     out_valid/out_ready  frame_fresh, cell_index, cell_distance, last
//
// An 8x8 zone, a dropped zone or a blank request is handled in idle; a 4x4 zone
// that lands writes one cell in idle and the rest in ST_BLOCK, one frame-store
// write per cell of its 2x2 block. A fresh read issues 64 RAM reads, one per
// cycle unless stalled, with the input held off until it is back in idle; a
// stale read gives one result. Output stalls back-pressure the read stream; zone
// requests are taken while the last results of a read still wait at the output.
// Reset clears the written mask, fresh and open flags; the RAM is not cleared.
module zone_grid_to_frame_remap (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_kind,
  input  logic [5:0]  in_zone_num,
  input  logic [6:0]  in_zone_count,
  input  logic [2:0]  in_target_count,
  input  logic [7:0]  in_zone_status,
  input  logic [15:0] in_range_mm,
  input  logic        in_last_zone,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_frame_fresh,
  output logic [5:0]  out_cell_index,
  output logic [15:0] out_cell_distance,
  output logic        out_last
);

  zgfr_pkg::state_t    state_r, state_nxt;
  zgfr_pkg::zone_map_t zmap;

  logic [zgfr_pkg::FRAME_CELLS-1:0] mask_r, mask_nxt;
  logic        fresh_r, fresh_nxt;
  logic        open_r, open_nxt;
  logic [1:0]  blk_r, blk_nxt;
  logic [5:0]  base_r, base_nxt;
  logic [15:0] dist_r, dist_nxt;
  logic [zgfr_pkg::ISS_W-1:0] iss_r, iss_nxt;

  logic        mem_we, mem_re;
  logic [5:0]  mem_waddr;
  logic [15:0] mem_wdata, mem_rdata;
  logic [15:0] zone_dist;

  logic        p_r, p_wr_r;
  logic [5:0]  p_idx_r;
  logic        out_load, stale_load;
  logic        o_valid_r, o_fresh_r, o_last_r;
  logic [5:0]  o_idx_r;
  logic [15:0] o_dist_r;

  // zone mapping
  zgfr_zone_map u_map (
    .zone_num   (in_zone_num),
    .zone_count (in_zone_count),
    .zmap       (zmap)
  );

  // distance kept only with a target and a valid status
  assign zone_dist = ((in_target_count != 3'd0) && (in_zone_status == 8'd0)) ?
                     in_range_mm : 16'd0;

  // read stage moves into the output register when it is free
  assign out_load = p_r && (!o_valid_r || out_ready);

  // next state and control
  always_comb begin
    state_nxt  = state_r;
    mask_nxt   = mask_r;
    fresh_nxt  = fresh_r;
    open_nxt   = open_r;
    blk_nxt    = blk_r;
    base_nxt   = base_r;
    dist_nxt   = dist_r;
    iss_nxt    = iss_r;
    in_ready   = 1'b0;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_waddr  = zmap.base;
    mem_wdata  = zone_dist;
    stale_load = 1'b0;
    case (state_r)
      zgfr_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (zgfr_pkg::kind_t'(in_kind))
            zgfr_pkg::KIND_ZONE: begin
              // first zone after a closed frame starts a new one
              mask_nxt = open_r ? mask_r : '0;
              open_nxt = 1'b1;
              if (zmap.hit) begin
                mem_we              = 1'b1;
                mask_nxt[zmap.base] = 1'b1;
                if (zmap.block) begin
                  state_nxt = zgfr_pkg::ST_BLOCK;
                  blk_nxt   = 2'd1;
                  base_nxt  = zmap.base;
                  dist_nxt  = zone_dist;
                end
              end
              if (in_last_zone) begin
                fresh_nxt = 1'b1;
                open_nxt  = 1'b0;
              end
            end
            zgfr_pkg::KIND_BLANK: begin
              mask_nxt  = '0;
              fresh_nxt = 1'b1;
              open_nxt  = 1'b0;
            end
            zgfr_pkg::KIND_READ: begin
              if (fresh_r) begin
                state_nxt = zgfr_pkg::ST_READ;
                iss_nxt   = '0;
                fresh_nxt = 1'b0;
              end else begin
                state_nxt = zgfr_pkg::ST_STALE;
              end
            end
            default: ;
          endcase
        end
      end
      zgfr_pkg::ST_BLOCK: begin
        // remaining cells of the 2x2 block: +1, +8, +9
        mem_we              = 1'b1;
        mem_waddr           = base_r + {2'b00, blk_r[1], 2'b00, blk_r[0]};
        mem_wdata           = dist_r;
        mask_nxt[mem_waddr] = 1'b1;
        blk_nxt             = blk_r + 2'd1;
        if (blk_r == 2'd3) begin
          state_nxt = zgfr_pkg::ST_IDLE;
        end
      end
      zgfr_pkg::ST_READ: begin
        if (iss_r[zgfr_pkg::ISS_W-1]) begin
          state_nxt = zgfr_pkg::ST_IDLE;
        end else if (!p_r || out_load) begin
          mem_re  = 1'b1;
          iss_nxt = iss_r + 7'd1;
        end
      end
      zgfr_pkg::ST_STALE: begin
        // wait until earlier results are out of the read stage
        if (!p_r && (!o_valid_r || out_ready)) begin
          stale_load = 1'b1;
          state_nxt  = zgfr_pkg::ST_IDLE;
        end
      end
      default: state_nxt = zgfr_pkg::ST_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= zgfr_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r  <= '0;
      fresh_r <= 1'b0;
      open_r  <= 1'b0;
      blk_r   <= '0;
      iss_r   <= '0;
    end else begin
      mask_r  <= mask_nxt;
      fresh_r <= fresh_nxt;
      open_r  <= open_nxt;
      blk_r   <= blk_nxt;
      iss_r   <= iss_nxt;
    end
  end

  // block payload
  always_ff @(posedge clk) begin
    base_r <= base_nxt;
    dist_r <= dist_nxt;
  end

  zgfr_frame_mem u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (iss_r[5:0]),
    .rdata (mem_rdata)
  );

  // read stage alongside the RAM output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_r <= 1'b0;
    end else if (mem_re) begin
      p_r <= 1'b1;
    end else if (out_load) begin
      p_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      p_idx_r <= iss_r[5:0];
      p_wr_r  <= mask_r[iss_r[5:0]];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_valid_r <= 1'b0;
    end else if (out_load || stale_load) begin
      o_valid_r <= 1'b1;
    end else if (out_ready) begin
      o_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      o_fresh_r <= 1'b1;
      o_idx_r   <= p_idx_r;
      o_dist_r  <= p_wr_r ? mem_rdata : 16'd0;
      o_last_r  <= (p_idx_r == 6'(zgfr_pkg::FRAME_CELLS - 1));
    end else if (stale_load) begin
      o_fresh_r <= 1'b0;
      o_idx_r   <= '0;
      o_dist_r  <= '0;
      o_last_r  <= 1'b1;
    end
  end

  assign out_valid         = o_valid_r;
  assign out_frame_fresh   = o_fresh_r;
  assign out_cell_index    = o_idx_r;
  assign out_cell_distance = o_dist_r;
  assign out_last          = o_last_r;

  // block fill writes the RAM every cycle
  a_block_writes: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == zgfr_pkg::ST_BLOCK) |-> mem_we)
    else $error("block fill cycle without a RAM write");

  // RAM reads only while streaming
  a_read_in_stream: assert property (@(posedge clk) disable iff (!rst_n)
    mem_re |-> (state_r == zgfr_pkg::ST_READ) && !iss_r[zgfr_pkg::ISS_W-1])
    else $error("RAM read outside read stream");

  // read request clears the fresh flag
  a_read_clears_fresh: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_kind == zgfr_pkg::KIND_READ)) |=> !fresh_r)
    else $error("fresh flag not cleared by read");

  // a held read stage is not overwritten
  a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (p_r && !out_load) |-> !mem_re)
    else $error("read stage overwritten while stalled");

  // stale result never overtakes streamed cells
  a_stale_order: assert property (@(posedge clk) disable iff (!rst_n)
    stale_load |-> !p_r && !out_load)
    else $error("stale result issued with cells pending");

endmodule

// File: rtl/core/zgfr_frame_mem.sv
// Frame store: 64 x 16-bit synchronous RAM, one write and one read port.
// Read data is registered and holds while no read is issued. Uses zgfr_pkg.
module zgfr_frame_mem (
  input  logic                         clk,
  input  logic                         we,
  input  logic [zgfr_pkg::CELL_W-1:0]  waddr,
  input  logic [zgfr_pkg::DIST_W-1:0]  wdata,
  input  logic                         re,
  input  logic [zgfr_pkg::CELL_W-1:0]  raddr,
  output logic [zgfr_pkg::DIST_W-1:0]  rdata
);

  logic [zgfr_pkg::DIST_W-1:0] mem [zgfr_pkg::FRAME_CELLS];
  logic [zgfr_pkg::DIST_W-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/core/zgfr_zone_map.sv
// Zone-to-cell mapping: range check, mode select and mirrored column.
// Combinational; uses zgfr_pkg for the mapping struct.
module zgfr_zone_map (
  input  logic [5:0]          zone_num,
  input  logic [6:0]          zone_count,
  output zgfr_pkg::zone_map_t zmap
);

  logic full;

  // 64 or more zones: one zone per cell
  assign full = zone_count[6];

  always_comb begin
    zmap.block = !full;
    zmap.hit   = ({1'b0, zone_num} < zone_count) && (full || !(|zone_num[5:4]));
    if (full) begin
      // row = idx/8, col = 7 - idx%8
      zmap.base = {zone_num[5:3], ~zone_num[2:0]};
    end else begin
      // 2x2 block: row = (idx/4)*2, col = (3 - idx%4)*2
      zmap.base = {zone_num[3:2], 1'b0, ~zone_num[1:0], 1'b0};
    end
  end

endmodule
